/* hdl/atc_pkg.sv */
// ----------------------------------------------------------------------------
// atc_pkg
// Shared constants, types and scaling factors of the airflow trend classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package atc_pkg;

    // Group and calibration sizes
    localparam int unsigned SAMPLES       = 10;
    localparam int unsigned BASE_READINGS = 10;

    // Converter and flow scaling
    localparam int unsigned ADC_FULL     = 1023;
    localparam int unsigned SPAN_MMS     = 3750;
    localparam int unsigned OFFSET_MMS   = 750;
    localparam int unsigned CHANGE_SCALE = 1000;

    // Field widths
    localparam int unsigned SAMPLE_W   = 10;
    localparam int unsigned FLOW_W     = 13;
    localparam int unsigned Q_W        = FLOW_W - 1;
    localparam int unsigned THR_W      = 10;
    localparam int unsigned LIMIT_W    = 8;
    localparam int unsigned CMP_W      = THR_W + Q_W;
    localparam int unsigned CFG_ADDR_W = 2;
    localparam int unsigned CFG_DATA_W = (THR_W > LIMIT_W) ? THR_W : LIMIT_W;

    // Stream widths
    localparam int unsigned S_TDATA_W = 16;
    localparam int unsigned M_TDATA_W = 56;
    localparam int unsigned M_TUSER_W = 2;

    // Accumulator widths
    localparam int unsigned SUM_MAX = SAMPLES * ADC_FULL;
    localparam int unsigned TOT_MAX = SAMPLES * BASE_READINGS * ADC_FULL;
    localparam int unsigned SUM_W   = $clog2(SUM_MAX + 1);
    localparam int unsigned TOT_W   = $clog2(TOT_MAX + 1);
    localparam int unsigned IDX_W   = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
    localparam int unsigned CAL_W   = (BASE_READINGS > 1) ? $clog2(BASE_READINGS) : 1;

    // Output queue
    localparam int unsigned OQ_DEPTH = 4;
    localparam int unsigned OQ_PTR_W = $clog2(OQ_DEPTH);
    localparam int unsigned OQ_CNT_W = $clog2(2 * OQ_DEPTH);

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_THRESHOLD    = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] REG_STABLE_LIMIT = CFG_ADDR_W'(1);

    // Register reset values
    localparam logic [THR_W-1:0]   THR_RESET   = THR_W'(10);
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(3);

    // Greatest common divisor by repeated subtraction, elaboration only
    function automatic longint unsigned atc_gcd(input longint unsigned a,
                                                input longint unsigned b);
        longint unsigned x;
        longint unsigned y;
        x = a;
        y = b;
        while (x != y) begin
            if (x > y) begin
                x = x - y;
            end else begin
                y = y - x;
            end
        end
        return x;
    endfunction

    // Flow scaling: floor(sum * SPAN / (ADC_FULL * SAMPLES)) via reciprocal
    localparam longint unsigned FLOW_DEN_RAW = longint'(ADC_FULL) * SAMPLES;
    localparam longint unsigned FLOW_G       = atc_gcd(SPAN_MMS, FLOW_DEN_RAW);
    localparam longint unsigned FLOW_NUM     = SPAN_MMS / FLOW_G;
    localparam longint unsigned FLOW_DEN     = FLOW_DEN_RAW / FLOW_G;
    localparam longint unsigned FLOW_NMAX    = longint'(SUM_MAX) * FLOW_NUM;
    localparam int unsigned     FLOW_SHIFT   = $clog2(FLOW_NMAX + 1) + $clog2(FLOW_DEN);
    localparam longint unsigned FLOW_RECIP   =
        ((longint'(1) << FLOW_SHIFT) + FLOW_DEN - 1) / FLOW_DEN;
    localparam longint unsigned FLOW_MUL     = FLOW_NUM * FLOW_RECIP;
    localparam int unsigned     FLOW_MUL_W   = $clog2(FLOW_MUL + 1);
    localparam int unsigned     FLOW_PROD_W  = SUM_W + FLOW_MUL_W;

    // Baseline scaling over the whole calibration total
    localparam longint unsigned BASE_DEN_RAW = FLOW_DEN_RAW * BASE_READINGS;
    localparam longint unsigned BASE_G       = atc_gcd(SPAN_MMS, BASE_DEN_RAW);
    localparam longint unsigned BASE_NUM     = SPAN_MMS / BASE_G;
    localparam longint unsigned BASE_DEN     = BASE_DEN_RAW / BASE_G;
    localparam longint unsigned BASE_NMAX    = longint'(TOT_MAX) * BASE_NUM;
    localparam int unsigned     BASE_SHIFT   = $clog2(BASE_NMAX + 1) + $clog2(BASE_DEN);
    localparam longint unsigned BASE_RECIP   =
        ((longint'(1) << BASE_SHIFT) + BASE_DEN - 1) / BASE_DEN;
    localparam longint unsigned BASE_MUL     = BASE_NUM * BASE_RECIP;
    localparam int unsigned     BASE_MUL_W   = $clog2(BASE_MUL + 1);
    localparam int unsigned     BASE_PROD_W  = TOT_W + BASE_MUL_W;

    typedef enum logic [1:0] {
        TREND_STABLE  = 2'd0,
        TREND_RISING  = 2'd1,
        TREND_FALLING = 2'd2
    } atc_trend_t;

    // Completed group from the accumulator
    typedef struct packed {
        logic             meas;
        logic             base_load;
        logic [SUM_W-1:0] gsum;
        logic [TOT_W-1:0] gtot;
    } atc_grp_t;

    // Scaled reading from the scaler
    typedef struct packed {
        logic                     meas;
        logic signed [FLOW_W-1:0] flow;
        logic signed [FLOW_W-1:0] base;
    } atc_rdg_t;

    // One result item
    typedef struct packed {
        atc_trend_t               status;
        logic signed [FLOW_W-1:0] peak;
        logic signed [FLOW_W-1:0] base;
        logic signed [FLOW_W-1:0] delta;
        logic signed [FLOW_W-1:0] flow;
    } atc_res_t;

endpackage

`default_nettype wire

/* hdl/airflow_trend_classifier.sv */
// ----------------------------------------------------------------------------
// airflow_trend_classifier
// Averages airflow sensor samples into readings and classifies their trend.
// ----------------------------------------------------------------------------
// Usage:
//   s_tdata[9:0] carries one 10-bit converter sample per item. Every SAMPLES
//   items form one reading. The first BASE_READINGS readings build the
//   baseline and give no result; each later reading gives one result item.
//   The register port (cfg_wr_en, cfg_addr, cfg_wdata) sets the change
//   threshold (index 0) and the stable limit (index 1); write it while idle.
// Throughput: one sample item per cycle while s_tready is high.
// Path: the result of the item that completes a reading passes the group
//   register, the scaling multiplier, the compare multiplier and then the
//   result queue before it is shown on m_tvalid.
// Reset: aresetn clears the sums, the calibration (it starts again), the
//   baseline, peak, trend state and the queue; the registers return to
//   threshold 10 and stable limit 3.
// Stall: results wait in a four-item queue. s_tready falls only while the
//   queued results plus the readings in the pipeline fill that queue.
// ----------------------------------------------------------------------------
`default_nettype none

module airflow_trend_classifier (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // Sample items
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [atc_pkg::S_TDATA_W-1:0]  s_tdata,   // [9:0] raw_sample
    // Result items
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // [12:0] flow_mms, [25:13] delta_mms, [38:26] baseline_mms,
    // [51:39] peak_mms, [55:52] zero
    output logic [atc_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic [atc_pkg::M_TUSER_W-1:0]       m_tuser,   // [1:0] trend_status
    // Register writes
    input  wire logic                           cfg_wr_en,
    input  wire logic [atc_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [atc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    atc_pkg::atc_grp_t grp;
    atc_pkg::atc_rdg_t rdg;
    atc_pkg::atc_res_t res_data;
    atc_pkg::atc_res_t out_data;

    logic                         in_accept;
    logic                         cmp_busy;
    logic                         res_valid;
    logic [atc_pkg::OQ_CNT_W-1:0] q_count;
    logic [atc_pkg::OQ_CNT_W-1:0] occupancy;

    // Count every reading still in flight against the queue space
    assign occupancy = q_count
                     + atc_pkg::OQ_CNT_W'(grp.meas)
                     + atc_pkg::OQ_CNT_W'(rdg.meas)
                     + atc_pkg::OQ_CNT_W'(cmp_busy);
    assign s_tready  = (occupancy < atc_pkg::OQ_CNT_W'(atc_pkg::OQ_DEPTH));
    assign in_accept = s_tvalid && s_tready;

    atc_accum u_accum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .in_sample (s_tdata[atc_pkg::SAMPLE_W-1:0]),
        .grp       (grp)
    );

    atc_scale u_scale (
        .aclk    (aclk),
        .aresetn (aresetn),
        .grp     (grp),
        .rdg     (rdg)
    );

    atc_classify u_classify (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .rdg       (rdg),
        .cmp_busy  (cmp_busy),
        .res_valid (res_valid),
        .res_data  (res_data)
    );

    atc_outq u_outq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (res_valid),
        .wr_data  (res_data),
        .rd_valid (m_tvalid),
        .rd_ready (m_tready),
        .rd_data  (out_data),
        .count    (q_count)
    );

    assign m_tdata = {
        (atc_pkg::M_TDATA_W - 4 * atc_pkg::FLOW_W)'(0),
        out_data.peak,
        out_data.base,
        out_data.delta,
        out_data.flow
    };
    assign m_tuser = out_data.status;

endmodule

`default_nettype wire

/* hdl/atc_accum.sv */
// ----------------------------------------------------------------------------
// atc_accum
// Sums samples into groups and totals the calibration groups.
// ----------------------------------------------------------------------------
`default_nettype none

module atc_accum (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         in_accept,
    input  wire logic [atc_pkg::SAMPLE_W-1:0] in_sample,
    output atc_pkg::atc_grp_t                 grp
);

    logic [atc_pkg::IDX_W-1:0] idx_reg, idx_next;
    logic [atc_pkg::SUM_W-1:0] sum_reg, sum_next;
    logic [atc_pkg::CAL_W-1:0] cal_cnt_reg, cal_cnt_next;
    logic [atc_pkg::TOT_W-1:0] cal_tot_reg, cal_tot_next;
    logic                      calibrated_reg, calibrated_next;
    logic                      meas_reg, meas_next;
    logic                      base_reg, base_next;
    logic [atc_pkg::SUM_W-1:0] gsum_reg;
    logic [atc_pkg::TOT_W-1:0] gtot_reg;

    logic [atc_pkg::SUM_W-1:0] group_sum;
    logic [atc_pkg::TOT_W-1:0] tot_sum;
    logic                      last_smp;
    logic                      last_cal;

    assign group_sum = sum_reg + atc_pkg::SUM_W'(in_sample);
    assign tot_sum   = cal_tot_reg + atc_pkg::TOT_W'(group_sum);
    assign last_smp  = (idx_reg == atc_pkg::IDX_W'(atc_pkg::SAMPLES - 1));
    assign last_cal  = (cal_cnt_reg == atc_pkg::CAL_W'(atc_pkg::BASE_READINGS - 1));

    always_comb begin
        idx_next        = idx_reg;
        sum_next        = sum_reg;
        cal_cnt_next    = cal_cnt_reg;
        cal_tot_next    = cal_tot_reg;
        calibrated_next = calibrated_reg;
        meas_next       = 1'b0;
        base_next       = 1'b0;
        if (in_accept) begin
            if (last_smp) begin
                idx_next = '0;
                sum_next = '0;
                if (calibrated_reg) begin
                    meas_next = 1'b1;
                end else if (last_cal) begin
                    // close calibration and hand the total to the scaler
                    base_next       = 1'b1;
                    calibrated_next = 1'b1;
                    cal_cnt_next    = '0;
                    cal_tot_next    = '0;
                end else begin
                    cal_cnt_next = cal_cnt_reg + 1'b1;
                    cal_tot_next = tot_sum;
                end
            end else begin
                idx_next = idx_reg + 1'b1;
                sum_next = group_sum;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg        <= '0;
            sum_reg        <= '0;
            cal_cnt_reg    <= '0;
            cal_tot_reg    <= '0;
            calibrated_reg <= 1'b0;
            meas_reg       <= 1'b0;
            base_reg       <= 1'b0;
        end else begin
            idx_reg        <= idx_next;
            sum_reg        <= sum_next;
            cal_cnt_reg    <= cal_cnt_next;
            cal_tot_reg    <= cal_tot_next;
            calibrated_reg <= calibrated_next;
            meas_reg       <= meas_next;
            base_reg       <= base_next;
        end
    end

    always_ff @(posedge aclk) begin
        gsum_reg <= group_sum;
        gtot_reg <= tot_sum;
    end

    assign grp.meas      = meas_reg;
    assign grp.base_load = base_reg;
    assign grp.gsum      = gsum_reg;
    assign grp.gtot      = gtot_reg;

endmodule

`default_nettype wire

/* hdl/atc_scale.sv */
// ----------------------------------------------------------------------------
// atc_scale
// Turns group sums into flow readings and latches the calibration baseline.
// ----------------------------------------------------------------------------
`default_nettype none

module atc_scale (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  atc_pkg::atc_grp_t grp,
    output atc_pkg::atc_rdg_t rdg
);

    localparam int unsigned FPW = atc_pkg::FLOW_PROD_W;
    localparam int unsigned BPW = atc_pkg::BASE_PROD_W;

    logic                             meas_reg;
    logic signed [atc_pkg::FLOW_W-1:0] flow_reg, flow_next;
    logic signed [atc_pkg::FLOW_W-1:0] base_reg, base_next;

    logic [FPW-1:0]              prod_f;
    logic [BPW-1:0]              prod_b;
    logic [atc_pkg::Q_W-1:0]     q_flow;
    logic [atc_pkg::Q_W-1:0]     q_base;

    // Reciprocal multiply: the shifted product is the exact floor quotient
    assign prod_f = FPW'(grp.gsum) * FPW'(atc_pkg::FLOW_MUL);
    assign prod_b = BPW'(grp.gtot) * BPW'(atc_pkg::BASE_MUL);
    assign q_flow = prod_f[atc_pkg::FLOW_SHIFT +: atc_pkg::Q_W];
    assign q_base = prod_b[atc_pkg::BASE_SHIFT +: atc_pkg::Q_W];

    always_comb begin
        flow_next = atc_pkg::FLOW_W'({1'b0, q_flow} - atc_pkg::FLOW_W'(atc_pkg::OFFSET_MMS));
        base_next = base_reg;
        if (grp.base_load) begin
            base_next = atc_pkg::FLOW_W'({1'b0, q_base}
                                         - atc_pkg::FLOW_W'(atc_pkg::OFFSET_MMS));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            meas_reg <= 1'b0;
            base_reg <= '0;
        end else begin
            meas_reg <= grp.meas;
            base_reg <= base_next;
        end
    end

    always_ff @(posedge aclk) begin
        flow_reg <= flow_next;
    end

    assign rdg.meas = meas_reg;
    assign rdg.flow = flow_reg;
    assign rdg.base = base_reg;

endmodule

`default_nettype wire

/* hdl/atc_classify.sv */
// ----------------------------------------------------------------------------
// atc_classify
// Holds the registers, tests each reading against the baseline and tracks
// trend, peak and the stable run.
// ----------------------------------------------------------------------------
`default_nettype none

module atc_classify (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [atc_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [atc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  atc_pkg::atc_rdg_t                   rdg,
    output logic                                cmp_busy,
    output logic                                res_valid,
    output atc_pkg::atc_res_t                   res_data
);

    localparam int unsigned FW = atc_pkg::FLOW_W;
    localparam int unsigned QW = atc_pkg::Q_W;
    localparam int unsigned CW = atc_pkg::CMP_W;
    localparam int unsigned LW = atc_pkg::LIMIT_W;

    // Registers
    logic [atc_pkg::THR_W-1:0] thr_reg;
    logic [LW-1:0]             lim_reg;

    // Compare stage
    logic                 c_meas_reg;
    logic signed [FW-1:0] c_flow_reg;
    logic signed [FW-1:0] c_delta_reg;
    logic signed [FW-1:0] c_base_reg;
    logic [CW-1:0]        c_lhs_reg;
    logic [CW-1:0]        c_rhs_reg;

    // Trend state
    logic signed [FW-1:0] prev_reg, prev_next;
    logic signed [FW-1:0] peak_reg, peak_next;
    logic [LW-1:0]        run_reg, run_next;

    logic signed [FW-1:0] delta;
    logic [FW-1:0]        neg_delta;
    logic [FW-1:0]        neg_base;
    logic [QW-1:0]        abs_delta;
    logic [QW-1:0]        abs_base;
    logic [CW-1:0]        lhs;
    logic [CW-1:0]        rhs;

    logic                 stable;
    logic signed [FW-1:0] peak_cur;
    logic [LW:0]          run_inc;
    atc_pkg::atc_trend_t  status;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= atc_pkg::THR_RESET;
            lim_reg <= atc_pkg::LIMIT_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                atc_pkg::REG_THRESHOLD: begin
                    thr_reg <= cfg_wdata[atc_pkg::THR_W-1:0];
                end
                atc_pkg::REG_STABLE_LIMIT: begin
                    lim_reg <= cfg_wdata[LW-1:0];
                end
                default: begin
                    // drop writes outside the register list
                end
            endcase
        end
    end

    // Compare stage: |delta| * 1000 against threshold * |baseline|
    assign delta     = rdg.flow - rdg.base;
    assign neg_delta = -delta;
    assign neg_base  = -rdg.base;
    assign abs_delta = delta[FW-1] ? neg_delta[QW-1:0] : delta[QW-1:0];
    assign abs_base  = rdg.base[FW-1] ? neg_base[QW-1:0] : rdg.base[QW-1:0];
    assign lhs       = CW'(abs_delta) * CW'(atc_pkg::CHANGE_SCALE);
    assign rhs       = CW'(thr_reg) * CW'(abs_base);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_meas_reg <= 1'b0;
        end else begin
            c_meas_reg <= rdg.meas;
        end
    end

    always_ff @(posedge aclk) begin
        c_flow_reg  <= rdg.flow;
        c_delta_reg <= delta;
        c_base_reg  <= rdg.base;
        c_lhs_reg   <= lhs;
        c_rhs_reg   <= rhs;
    end

    // Trend stage
    assign stable   = (c_lhs_reg <= c_rhs_reg);
    assign peak_cur = (c_flow_reg > peak_reg) ? c_flow_reg : peak_reg;
    assign run_inc  = {1'b0, run_reg} + 1'b1;

    always_comb begin
        if (stable) begin
            status = atc_pkg::TREND_STABLE;
        end else if (c_flow_reg > prev_reg) begin
            status = atc_pkg::TREND_RISING;
        end else begin
            status = atc_pkg::TREND_FALLING;
        end
    end

    always_comb begin
        prev_next = prev_reg;
        peak_next = peak_reg;
        run_next  = run_reg;
        if (c_meas_reg) begin
            prev_next = c_flow_reg;
            peak_next = peak_cur;
            if (stable) begin
                // a long enough stable run restarts the peak at this flow
                if (run_inc > {1'b0, lim_reg}) begin
                    peak_next = c_flow_reg;
                    run_next  = '0;
                end else begin
                    run_next = run_inc[LW-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg <= '0;
            peak_reg <= '0;
            run_reg  <= '0;
        end else begin
            prev_reg <= prev_next;
            peak_reg <= peak_next;
            run_reg  <= run_next;
        end
    end

    assign cmp_busy        = c_meas_reg;
    assign res_valid       = c_meas_reg;
    assign res_data.status = status;
    assign res_data.peak   = peak_cur;
    assign res_data.base   = c_base_reg;
    assign res_data.delta  = c_delta_reg;
    assign res_data.flow   = c_flow_reg;

endmodule

`default_nettype wire

/* hdl/atc_outq.sv */
// ----------------------------------------------------------------------------
// atc_outq
// Small result queue that decouples the pipeline from the result receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module atc_outq (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         wr_en,
    input  atc_pkg::atc_res_t                 wr_data,
    output logic                              rd_valid,
    input  wire logic                         rd_ready,
    output atc_pkg::atc_res_t                 rd_data,
    output logic [atc_pkg::OQ_CNT_W-1:0]      count
);

    atc_pkg::atc_res_t q_reg [atc_pkg::OQ_DEPTH];

    logic [atc_pkg::OQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [atc_pkg::OQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [atc_pkg::OQ_CNT_W-1:0] cnt_reg, cnt_next;
    logic                         pop;

    assign rd_valid = (cnt_reg != '0);
    assign pop      = rd_valid && rd_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (wr_en) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        case ({wr_en, pop})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            q_reg[wr_ptr_reg] <= wr_data;
        end
    end

    assign rd_data = q_reg[rd_ptr_reg];
    assign count   = cnt_reg;

endmodule

`default_nettype wire

/* hdl/atc_checker.sv */
// ----------------------------------------------------------------------------
// atc_checker
// Port-level checks on the result channel of the airflow trend classifier.
// ----------------------------------------------------------------------------
`default_nettype none

module atc_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [atc_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic [atc_pkg::M_TUSER_W-1:0] m_tuser
);

    // Reset empties the result queue
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result pending after reset");

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result withdrawn while stalled");

    // Delta is flow minus baseline, modulo the field width
    a_delta: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[25:13] == 13'(m_tdata[12:0] - m_tdata[38:26])))
        else $error("delta does not match flow and baseline");

    // Reported peak already includes this reading
    a_peak: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[51:39]) >= $signed(m_tdata[12:0])))
        else $error("peak below current flow");

    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser != 2'd3) && (m_tdata[55:52] == 4'd0))
        else $error("bad status code or padding");

endmodule

bind airflow_trend_classifier atc_checker u_atc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

/* dv/tb_airflow_trend_classifier.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_airflow_trend_classifier
// Self-checking bench for the airflow trend classifier.
// ----------------------------------------------------------------------------
// Feeds converter samples in whole readings: a calibration run, a few
// readings at the converter limits, then random readings around the
// baseline, drifting, noisy and repeated. A reading ledger predicts every
// result and checks the outputs field by field. Registers are reprogrammed
// between phases while the block is idle. Both stream sides idle at random.
// ----------------------------------------------------------------------------

class trend_ledger;
    logic [atc_pkg::THR_W-1:0]   threshold;
    logic [atc_pkg::LIMIT_W-1:0] stable_cap;

    int unsigned group_pos;
    int unsigned group_total;
    int unsigned calib_sum;
    int unsigned calib_count;
    bit          calibrated;
    int          baseline;
    int          peak;
    int          last_flow;
    int unsigned stable_count;

    atc_pkg::atc_res_t pending_readings[$];
    int                errors;
    int                results_seen;

    function new();
        threshold    = atc_pkg::THR_RESET;
        stable_cap   = atc_pkg::LIMIT_RESET;
        group_pos    = 0;
        group_total  = 0;
        calib_sum    = 0;
        calib_count  = 0;
        calibrated   = 1'b0;
        baseline     = 0;
        peak         = 0;
        last_flow    = 0;
        stable_count = 0;
        errors       = 0;
        results_seen = 0;
    endfunction

    function void set_reg(logic [atc_pkg::CFG_ADDR_W-1:0] idx,
                          logic [atc_pkg::CFG_DATA_W-1:0] val);
        if (idx == atc_pkg::REG_THRESHOLD) begin
            threshold = val[atc_pkg::THR_W-1:0];
        end else if (idx == atc_pkg::REG_STABLE_LIMIT) begin
            stable_cap = val[atc_pkg::LIMIT_W-1:0];
        end
    endfunction

    function int to_flow(longint unsigned total, longint unsigned count);
        return int'((total * atc_pkg::SPAN_MMS) / (longint'(atc_pkg::ADC_FULL) * count))
               - int'(atc_pkg::OFFSET_MMS);
    endfunction

    function void take_sample(logic [atc_pkg::SAMPLE_W-1:0] raw);
        int unsigned         gsum;
        int                  flow;
        int                  delta;
        longint              mag_delta;
        longint              mag_base;
        atc_pkg::atc_trend_t trend;
        atc_pkg::atc_res_t   res;

        group_total += raw;
        group_pos++;
        if (group_pos < atc_pkg::SAMPLES) return;
        gsum        = group_total;
        group_pos   = 0;
        group_total = 0;

        if (!calibrated) begin
            calib_sum += gsum;
            calib_count++;
            if (calib_count >= atc_pkg::BASE_READINGS) begin
                baseline    = to_flow(calib_sum, atc_pkg::SAMPLES * atc_pkg::BASE_READINGS);
                calibrated  = 1'b1;
                calib_count = 0;
                calib_sum   = 0;
            end
            return;
        end

        flow = to_flow(gsum, atc_pkg::SAMPLES);
        if (flow > peak) peak = flow;
        delta     = flow - baseline;
        mag_delta = (delta < 0) ? -delta : delta;
        mag_base  = (baseline < 0) ? -baseline : baseline;
        if (mag_delta * atc_pkg::CHANGE_SCALE <= longint'(threshold) * mag_base) begin
            trend = atc_pkg::TREND_STABLE;
        end else if (flow > last_flow) begin
            trend = atc_pkg::TREND_RISING;
        end else begin
            trend = atc_pkg::TREND_FALLING;
        end

        res.flow   = atc_pkg::FLOW_W'(flow);
        res.delta  = atc_pkg::FLOW_W'(delta);
        res.base   = atc_pkg::FLOW_W'(baseline);
        res.peak   = atc_pkg::FLOW_W'(peak);
        res.status = trend;
        pending_readings.push_back(res);

        // a long enough stable run pulls the peak down to the present flow
        if (trend == atc_pkg::TREND_STABLE) begin
            if (stable_count + 1 > stable_cap) begin
                peak         = flow;
                stable_count = 0;
            end else begin
                stable_count++;
            end
        end
        last_flow = flow;
    endfunction

    function void check_field(string name, logic [atc_pkg::FLOW_W-1:0] want,
                              logic [atc_pkg::FLOW_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
            errors++;
        end
    endfunction

    function void check_reading(logic [atc_pkg::M_TDATA_W-1:0] data,
                                logic [atc_pkg::M_TUSER_W-1:0] user);
        atc_pkg::atc_res_t want;
        results_seen++;
        if (pending_readings.size() == 0) begin
            $error("unexpected result item: flow %0d", $signed(data[atc_pkg::FLOW_W-1:0]));
            errors++;
            return;
        end
        want = pending_readings.pop_front();
        check_field("flow_mms", want.flow, data[atc_pkg::FLOW_W-1:0]);
        check_field("delta_mms", want.delta, data[2*atc_pkg::FLOW_W-1:atc_pkg::FLOW_W]);
        check_field("baseline_mms", want.base,
                    data[3*atc_pkg::FLOW_W-1:2*atc_pkg::FLOW_W]);
        check_field("peak_mms", want.peak, data[4*atc_pkg::FLOW_W-1:3*atc_pkg::FLOW_W]);
        check_field("trend_status", atc_pkg::FLOW_W'(want.status), atc_pkg::FLOW_W'(user));
    endfunction

    function int pending();
        return pending_readings.size();
    endfunction
endclass

module tb_airflow_trend_classifier;

    localparam int CYCLE_LIMIT    = 200000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int HOLD_CYCLES    = 600;
    localparam int PHASES         = 7;
    localparam int PHASE_READINGS = 9;

    // indexes past the register list, written to check they are ignored
    localparam logic [atc_pkg::CFG_ADDR_W-1:0] REG_SPARE_LO = atc_pkg::CFG_ADDR_W'(2);
    localparam logic [atc_pkg::CFG_ADDR_W-1:0] REG_SPARE_HI = atc_pkg::CFG_ADDR_W'(3);

    typedef enum int {
        RD_BASE,
        RD_NEAR,
        RD_DRIFT,
        RD_NOISE,
        RD_REPEAT,
        RD_FLOOR,
        RD_CEILING
    } reading_kind_t;

    logic                           aclk = 1'b0;
    logic                           aresetn;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [atc_pkg::S_TDATA_W-1:0]  s_tdata;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [atc_pkg::M_TDATA_W-1:0]  m_tdata;
    logic [atc_pkg::M_TUSER_W-1:0]  m_tuser;
    logic                           cfg_wr_en;
    logic [atc_pkg::CFG_ADDR_W-1:0] cfg_addr;
    logic [atc_pkg::CFG_DATA_W-1:0] cfg_wdata;

    trend_ledger ledger = new();

    int          cycle_count = 0;
    int          send_quiet  = 0;
    int          recv_quiet  = 0;
    bit          zero_base;
    int          calib_level;
    int          drift_level;
    logic [atc_pkg::SAMPLE_W-1:0] last_group [atc_pkg::SAMPLES];

    airflow_trend_classifier dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Mostly random gaps, now and then a stretch of back-to-back items
    function automatic int draw_gap(ref int quiet_left);
        if (quiet_left > 0) begin
            quiet_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            quiet_left = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 7);
    endfunction

    function automatic logic [atc_pkg::SAMPLE_W-1:0] clamp_sample(int v);
        if (v < 0) return '0;
        if (v > int'(atc_pkg::ADC_FULL)) return atc_pkg::SAMPLE_W'(atc_pkg::ADC_FULL);
        return atc_pkg::SAMPLE_W'(v);
    endfunction

    // Calibration pattern; with a zero baseline the group sum is 2046,
    // which scales to exactly 0 mm/s
    function automatic int level_at(int pos);
        if (zero_base) return (pos < 6) ? 205 : 204;
        return calib_level;
    endfunction

    function automatic reading_kind_t pick_kind();
        int r;
        r = $urandom_range(0, 19);
        if (r < 8)   return RD_NEAR;
        if (r < 12)  return RD_DRIFT;
        if (r < 15)  return RD_NOISE;
        if (r < 18)  return RD_REPEAT;
        if (r == 18) return RD_FLOOR;
        return RD_CEILING;
    endfunction

    task automatic send_sample(input logic [atc_pkg::SAMPLE_W-1:0] raw);
        int gap;
        gap = draw_gap(send_quiet);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= atc_pkg::S_TDATA_W'(raw);
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        ledger.take_sample(raw);
    endtask

    task automatic send_reading(input reading_kind_t kind);
        logic [atc_pkg::SAMPLE_W-1:0] grp [atc_pkg::SAMPLES];
        int                           amp;
        amp = $urandom_range(0, 6);
        if (kind == RD_DRIFT) begin
            drift_level = drift_level + $urandom_range(0, 80) - 40;
            if (drift_level < 0) drift_level = 0;
            if (drift_level > int'(atc_pkg::ADC_FULL)) drift_level = atc_pkg::ADC_FULL;
        end
        for (int i = 0; i < atc_pkg::SAMPLES; i++) begin
            case (kind)
                RD_BASE:    grp[i] = clamp_sample(level_at(i));
                RD_NEAR:    grp[i] = clamp_sample(level_at(i) + $urandom_range(0, 2 * amp) - amp);
                RD_DRIFT:   grp[i] = clamp_sample(drift_level + $urandom_range(0, 8) - 4);
                RD_NOISE:   grp[i] = atc_pkg::SAMPLE_W'($urandom_range(0, atc_pkg::ADC_FULL));
                RD_REPEAT:  grp[i] = last_group[i];
                RD_FLOOR:   grp[i] = '0;
                default:    grp[i] = atc_pkg::SAMPLE_W'(atc_pkg::ADC_FULL);
            endcase
        end
        last_group = grp;
        for (int i = 0; i < atc_pkg::SAMPLES; i++) begin
            send_sample(grp[i]);
        end
    endtask

    // Hold the input until every reading is out and the pipeline is empty
    task automatic settle();
        s_tvalid <= 1'b0;
        while (ledger.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic program_regs(input logic [atc_pkg::THR_W-1:0] thr,
                                input logic [atc_pkg::LIMIT_W-1:0] cap);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= atc_pkg::REG_THRESHOLD;
        cfg_wdata <= atc_pkg::CFG_DATA_W'(thr);
        @(posedge aclk);
        cfg_addr  <= atc_pkg::REG_STABLE_LIMIT;
        cfg_wdata <= atc_pkg::CFG_DATA_W'(cap);
        @(posedge aclk);
        cfg_addr  <= REG_SPARE_LO;
        cfg_wdata <= atc_pkg::CFG_DATA_W'($urandom);
        @(posedge aclk);
        cfg_addr  <= REG_SPARE_HI;
        cfg_wdata <= atc_pkg::CFG_DATA_W'($urandom);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        ledger.set_reg(atc_pkg::REG_THRESHOLD, atc_pkg::CFG_DATA_W'(thr));
        ledger.set_reg(atc_pkg::REG_STABLE_LIMIT, atc_pkg::CFG_DATA_W'(cap));
        @(posedge aclk);
    endtask

    // Result side: random stalls, and one long hold-off to back the block up
    initial begin
        int gap;
        bit held;
        held = 1'b0;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            gap = draw_gap(recv_quiet);
            if (!held && ledger.results_seen >= 3) begin
                gap  = HOLD_CYCLES;
                held = 1'b1;
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            ledger.check_reading(m_tdata, m_tuser);
        end
    end

    initial begin
        logic [atc_pkg::THR_W-1:0]   thr;
        logic [atc_pkg::LIMIT_W-1:0] cap;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_wr_en <= 1'b0;
        cfg_addr  <= '0;
        cfg_wdata <= '0;
        zero_base   = ($urandom_range(0, 1) == 0);
        calib_level = $urandom_range(20, atc_pkg::ADC_FULL - 20);
        drift_level = zero_base ? 205 : calib_level;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin
                    thr = atc_pkg::THR_W'(10);
                    cap = atc_pkg::LIMIT_W'(3);
                end
                1: begin
                    thr = '0;
                    cap = '0;
                end
                2: begin
                    thr = '1;
                    cap = '1;
                end
                3: begin
                    thr = atc_pkg::THR_W'(1000);
                    cap = atc_pkg::LIMIT_W'(1);
                end
                default: begin
                    thr = atc_pkg::THR_W'($urandom_range(0, 1023));
                    cap = atc_pkg::LIMIT_W'($urandom_range(0, 6));
                end
            endcase
            program_regs(thr, cap);
            if (p == 0) begin
                for (int r = 0; r < atc_pkg::BASE_READINGS; r++) send_reading(RD_BASE);
                // first reading after calibration at the bottom of the range,
                // then the top twice, so the second is an equal flow
                send_reading(RD_FLOOR);
                send_reading(RD_CEILING);
                send_reading(RD_CEILING);
            end
            for (int r = 0; r < PHASE_READINGS; r++) send_reading(pick_kind());
            settle();
        end

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (ledger.errors == 0 && ledger.pending() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
